// File: design/pcbp_pkg.sv
// pcbp_pkg: shared types and constants of the prefix code bit packer
// no dependencies; used by every module under design/
`timescale 1ns / 1ps

package pcbp_pkg;

    // item operations carried in s_tuser
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_START  = 2'd1,
        OP_ENCODE = 2'd2,
        OP_FINISH = 2'd3
    } op_t;

    // field widths
    localparam int SYM_W   = 8;
    localparam int WORD_W  = 32;
    localparam int LEN_W   = 6;
    localparam int BYTE_W  = 8;

    // longest code word kept in the table
    localparam int MAX_CODE_LEN = 32;
    localparam int LEN_CAP      = (MAX_CODE_LEN < WORD_W) ? MAX_CODE_LEN : WORD_W;

    // leftover bits between items
    localparam int PEND_W  = 7;
    localparam int PCNT_W  = 3;

    // pending bits plus one code word, rounded up to whole bytes
    localparam int ACC_W   = 40;
    localparam int SUM_W   = 6;

    // at most four bytes per item
    localparam int MAX_RES = 4;
    localparam int RCNT_W  = 3;
    localparam int RIDX_W  = 2;

    // results of one item, handed from the packer to the output buffer
    typedef struct packed {
        logic [MAX_RES-1:0][BYTE_W-1:0] bytes;
        logic [RCNT_W-1:0]              n;
        logic                           byte_valid;
        logic                           last_flag;
    } res_t;

endpackage

// File: design/prefix_code_bit_packer.sv
// prefix_code_bit_packer: top level, input register, config register and submodules
// depends on pcbp_pkg, pcbp_code_table, pcbp_packer, pcbp_out_buf
//
//   channel | direction | tdata                                  | tuser        | tlast
//   s_      | in        | symbol, code_bits, code_length         | operation    | -
//   m_      | out       | out_byte                               | byte_valid   | final_marker
//   cfg_    | in        | total_code_bits (write only)           | -            | -
//
// an item waits in the input register (table read) until the output register is free, then its
// results load the output register
// an item holds the output register until each of its results is sent, at most 4 for an
// encode, the output channel moving one byte per cycle while m_tready is high; items with no
// result wait only for the output register to drain
// reset clears the table lengths at once through per-entry valid bits; no sweep
// a stall on m_ holds the output register, then the input register, then s_tready
`timescale 1ns / 1ps

module prefix_code_bit_packer #(
    parameter int SYMBOL_COUNT = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input item
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // symbol[7:0], code_bits[39:8], code_length[45:40], zero
    input  logic [1:0]  s_tuser,   // operation[1:0]
    // result item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic        m_tuser,   // byte_valid[0]
    output logic        m_tlast,   // final_marker
    // configuration
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);

    localparam int SYM_AW = $clog2(SYMBOL_COUNT);

    logic                        s_xfer;
    logic                        s1_adv;
    logic                        buf_free;
    logic                        s1_valid_reg, s1_valid_next;
    pcbp_pkg::op_t               s1_op_reg;
    logic                        s1_sym_ok_reg;
    logic [pcbp_pkg::PCNT_W-1:0] total_low_reg;

    pcbp_pkg::op_t               in_op;
    logic [pcbp_pkg::SYM_W-1:0]  in_sym;
    logic [pcbp_pkg::WORD_W-1:0] in_word;
    logic [pcbp_pkg::LEN_W-1:0]  in_len;
    logic                        in_sym_ok;

    logic [pcbp_pkg::WORD_W-1:0] tbl_word;
    logic [pcbp_pkg::LEN_W-1:0]  tbl_len;
    pcbp_pkg::res_t              res;

    // unpack the input transfer
    assign in_op     = pcbp_pkg::op_t'(s_tuser);
    assign in_sym    = s_tdata[7:0];
    assign in_word   = s_tdata[39:8];
    assign in_len    = s_tdata[45:40];
    assign in_sym_ok = ({1'b0, in_sym} < 9'(SYMBOL_COUNT));

    // handshake of the input register
    assign s1_adv        = s1_valid_reg && buf_free;
    assign s_tready      = !s1_valid_reg || buf_free;
    assign s_xfer        = s_tvalid && s_tready;
    assign s1_valid_next = s_xfer || (s1_valid_reg && !buf_free);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            s1_op_reg     <= in_op;
            s1_sym_ok_reg <= in_sym_ok;
        end
    end

    // only the low bits of the total bit count set the padding
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_low_reg <= '0;
        end else if (cfg_wr_en) begin
            total_low_reg <= cfg_wr_data[pcbp_pkg::PCNT_W-1:0];
        end
    end

    pcbp_code_table #(
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (s_xfer && (in_op == pcbp_pkg::OP_LOAD) && in_sym_ok),
        .wr_addr (in_sym[SYM_AW-1:0]),
        .wr_word (in_word),
        .wr_len  (in_len),
        .rd_en   (s_xfer),
        .rd_addr (in_sym[SYM_AW-1:0]),
        .rd_word (tbl_word),
        .rd_len  (tbl_len)
    );

    pcbp_packer u_packer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (s1_adv),
        .op      (s1_op_reg),
        .sym_ok  (s1_sym_ok_reg),
        .word    (tbl_word),
        .len     (tbl_len),
        .pad     (total_low_reg),
        .res     (res)
    );

    pcbp_out_buf u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (s1_adv),
        .res      (res),
        .free     (buf_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: design/pcbp_code_table.sv
// pcbp_code_table: per-symbol code word and length memories
// depends on pcbp_pkg; length entries carry valid bits so reset reads them as zero
`timescale 1ns / 1ps

module pcbp_code_table #(
    parameter int SYMBOL_COUNT = 256
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        wr_en,
    input  logic [$clog2(SYMBOL_COUNT)-1:0] wr_addr,
    input  logic [pcbp_pkg::WORD_W-1:0] wr_word,
    input  logic [pcbp_pkg::LEN_W-1:0]  wr_len,
    input  logic                        rd_en,
    input  logic [$clog2(SYMBOL_COUNT)-1:0] rd_addr,
    output logic [pcbp_pkg::WORD_W-1:0] rd_word,
    output logic [pcbp_pkg::LEN_W-1:0]  rd_len
);

    logic [pcbp_pkg::WORD_W-1:0] word_mem [SYMBOL_COUNT];
    logic [pcbp_pkg::LEN_W-1:0]  len_mem  [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0]     len_vld_reg;

    logic [pcbp_pkg::LEN_W-1:0]  len_capped;
    logic [pcbp_pkg::WORD_W-1:0] word_masked;
    logic [pcbp_pkg::WORD_W-1:0] rd_word_reg;
    logic [pcbp_pkg::LEN_W-1:0]  rd_len_reg;
    logic                        rd_vld_reg;

    // clamp the length and keep only the low code bits of the word
    always_comb begin
        if (wr_len > pcbp_pkg::LEN_W'(pcbp_pkg::LEN_CAP)) begin
            len_capped = pcbp_pkg::LEN_W'(pcbp_pkg::LEN_CAP);
        end else begin
            len_capped = wr_len;
        end
        word_masked = wr_word & ~({pcbp_pkg::WORD_W{1'b1}} << len_capped);
    end

    // memory write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            word_mem[wr_addr] <= word_masked;
            len_mem[wr_addr]  <= len_capped;
        end
        if (rd_en) begin
            rd_word_reg <= word_mem[rd_addr];
            rd_len_reg  <= len_mem[rd_addr];
        end
    end

    // valid bits, cleared together at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                len_vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= len_vld_reg[rd_addr];
            end
        end
    end

    // an entry never loaded reads as absent
    assign rd_word = rd_word_reg;
    assign rd_len  = rd_vld_reg ? rd_len_reg : '0;

endmodule

// File: design/pcbp_packer.sv
// pcbp_packer: appends code words to the leftover bits and cuts whole bytes
// depends on pcbp_pkg; holds the pending bit state between items
`timescale 1ns / 1ps

module pcbp_packer (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  pcbp_pkg::op_t               op,
    input  logic                        sym_ok,
    input  logic [pcbp_pkg::WORD_W-1:0] word,
    input  logic [pcbp_pkg::LEN_W-1:0]  len,
    input  logic [pcbp_pkg::PCNT_W-1:0] pad,
    output pcbp_pkg::res_t              res
);

    logic [pcbp_pkg::PEND_W-1:0] pend_bits_reg, pend_bits_next;
    logic [pcbp_pkg::PCNT_W-1:0] pend_cnt_reg, pend_cnt_next;

    logic [pcbp_pkg::ACC_W-1:0]  acc;
    logic [pcbp_pkg::ACC_W-1:0]  acc_left;
    logic [pcbp_pkg::SUM_W-1:0]  cnt;
    logic [pcbp_pkg::PCNT_W-1:0] pad_cnt;
    logic [pcbp_pkg::MAX_RES-1:0][pcbp_pkg::BYTE_W-1:0] enc_bytes;

    // zero bits needed to fill the last byte, kept to three bits
    assign pad_cnt = pcbp_pkg::PCNT_W'(0) - pad;

    // join leftover bits and the code word, then left-justify
    always_comb begin
        acc = ({{(pcbp_pkg::ACC_W-pcbp_pkg::PEND_W){1'b0}}, pend_bits_reg} << len)
            | pcbp_pkg::ACC_W'(word);
        cnt = pcbp_pkg::SUM_W'(pend_cnt_reg) + pcbp_pkg::SUM_W'(len);
        acc_left = acc << (pcbp_pkg::SUM_W'(pcbp_pkg::ACC_W) - cnt);
        for (int k = 0; k < pcbp_pkg::MAX_RES; k++) begin
            enc_bytes[k] = acc_left[pcbp_pkg::ACC_W-1-pcbp_pkg::BYTE_W*k -: pcbp_pkg::BYTE_W];
        end
    end

    // results and next pending state per operation
    always_comb begin
        res            = '0;
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        unique case (op)
            pcbp_pkg::OP_LOAD: begin
            end
            pcbp_pkg::OP_START: begin
                res.bytes[0]   = pcbp_pkg::BYTE_W'(pad_cnt);
                res.n          = pcbp_pkg::RCNT_W'(1);
                res.byte_valid = 1'b1;
                pend_bits_next = '0;
                pend_cnt_next  = '0;
            end
            pcbp_pkg::OP_ENCODE: begin
                if (sym_ok && (len != '0)) begin
                    res.bytes      = enc_bytes;
                    res.n          = cnt[pcbp_pkg::SUM_W-1:pcbp_pkg::PCNT_W];
                    res.byte_valid = 1'b1;
                    pend_cnt_next  = cnt[pcbp_pkg::PCNT_W-1:0];
                    pend_bits_next = acc[pcbp_pkg::PEND_W-1:0]
                                   & ~({pcbp_pkg::PEND_W{1'b1}} << cnt[pcbp_pkg::PCNT_W-1:0]);
                end
            end
            pcbp_pkg::OP_FINISH: begin
                res.bytes[0]   = pcbp_pkg::BYTE_W'(pend_bits_reg);
                res.n          = pcbp_pkg::RCNT_W'(1);
                res.byte_valid = (pend_cnt_reg != '0);
                res.last_flag  = 1'b1;
                pend_bits_next = '0;
                pend_cnt_next  = '0;
            end
            default: begin
            end
        endcase
    end

    // pending state moves only when the item leaves for the output buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
        end else if (adv) begin
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
        end
    end

    // bits above the pending count stay clear, so an empty flush sends zero
    a_pend_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_bits_reg >> pend_cnt_reg) == '0)
        else $error("pending bits set above pending count");

    a_finish_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && (op == pcbp_pkg::OP_FINISH) |=> (pend_cnt_reg == '0) && (pend_bits_reg == '0))
        else $error("pending bits survive a finish");

    a_res_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        adv |-> (res.n <= pcbp_pkg::RCNT_W'(pcbp_pkg::MAX_RES)))
        else $error("too many results for one item");

endmodule

// File: design/pcbp_out_buf.sv
// pcbp_out_buf: result register holding the bytes of one item, sent one per transfer
// depends on pcbp_pkg; takes a new item when empty or on its last transfer
`timescale 1ns / 1ps

module pcbp_out_buf (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        load,
    input  pcbp_pkg::res_t              res,
    output logic                        free,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [pcbp_pkg::BYTE_W-1:0] m_tdata,
    output logic                        m_tuser,
    output logic                        m_tlast
);

    logic [pcbp_pkg::MAX_RES-1:0][pcbp_pkg::BYTE_W-1:0] bytes_reg;
    logic [pcbp_pkg::RCNT_W-1:0] cnt_reg;
    logic [pcbp_pkg::RIDX_W-1:0] idx_reg;
    logic                        bv_reg;
    logic                        last_reg;
    logic                        xfer;

    assign xfer     = m_tvalid && m_tready;
    assign free     = (cnt_reg == '0) || ((cnt_reg == pcbp_pkg::RCNT_W'(1)) && m_tready);
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = bytes_reg[idx_reg];
    assign m_tuser  = bv_reg;
    assign m_tlast  = last_reg;

    // count and read pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end else if (load) begin
            cnt_reg <= res.n;
            idx_reg <= '0;
        end else if (xfer) begin
            cnt_reg <= cnt_reg - pcbp_pkg::RCNT_W'(1);
            idx_reg <= idx_reg + pcbp_pkg::RIDX_W'(1);
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (load) begin
            bytes_reg <= res.bytes;
            bv_reg    <= res.byte_valid;
            last_reg  <= res.last_flag;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= pcbp_pkg::RCNT_W'(pcbp_pkg::MAX_RES))
        else $error("output count out of range");

    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (4'(idx_reg) + 4'(cnt_reg)) <= 4'(pcbp_pkg::MAX_RES))
        else $error("read pointer runs past the stored bytes");

    a_last_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (cnt_reg == pcbp_pkg::RCNT_W'(1)) && (idx_reg == '0))
        else $error("finish result is not a single transfer");

endmodule

// File: test/prefix_code_bit_packer_tb.sv
// prefix_code_bit_packer_tb: self-checking bench for the prefix code bit packer
// drives table loads, headers, encodes and flushes and checks each output byte
// against an in-bench packing model; depends on pcbp_pkg and prefix_code_bit_packer
`timescale 1ns / 1ps

module prefix_code_bit_packer_tb;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 5000;
    localparam int PHASE_ITEMS   = 15;
    localparam int HOLD_CYCLES   = 200;
    localparam int MAX_PRINTS    = 60;

    // one expected byte on the output stream
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } out_beat_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata     = '0;   // symbol[7:0], code_bits[39:8], code_length[45:40], zero
    logic [1:0]  s_tuser     = '0;   // operation[1:0]
    logic        m_tvalid;
    logic        m_tready    = 1'b1;
    logic [7:0]  m_tdata;            // out_byte[7:0]
    logic        m_tuser;            // byte_valid[0]
    logic        m_tlast;            // final_marker
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = '0;

    // packing model state
    logic [31:0] word_of_sym [256];
    logic [5:0]  len_of_sym  [256];
    logic [6:0]  carry_bits     = '0;
    logic [2:0]  carry_cnt      = '0;
    logic [31:0] pad_total_bits = '0;
    out_beat_t   expected_bytes [$];

    int errors        = 0;
    int items_sent    = 0;
    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int rx_hold_left  = 0;
    int quiet_cycles  = 0;

    prefix_code_bit_packer uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // clock
    always #HALF_PERIOD aclk = ~aclk;

    // receiver: long hold-off first, otherwise random stalls
    always @(posedge aclk) begin
        if (rx_hold_left > 0) begin
            m_tready <= 1'b0;
            rx_hold_left = rx_hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // watchdog on cycles with no transfer on either stream
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        begin
            if (errors < MAX_PRINTS) begin
                $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
            end
            errors = errors + 1;
        end
    endtask

    // compare each output transfer with the oldest expected byte
    always @(posedge aclk) begin : check_results
        out_beat_t want;
        if (m_tvalid && m_tready) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch("unexpected output byte", 32'd0, {24'd0, m_tdata});
            end else begin
                want = expected_bytes.pop_front();
                if (m_tdata !== want.data) begin
                    report_mismatch("out_byte", {24'd0, want.data}, {24'd0, m_tdata});
                end
                if (m_tuser !== want.valid) begin
                    report_mismatch("byte_valid", {31'd0, want.valid}, {31'd0, m_tuser});
                end
                if (m_tlast !== want.last) begin
                    report_mismatch("final_marker", {31'd0, want.last}, {31'd0, m_tlast});
                end
            end
        end
    end

    function automatic void add_beat(input logic [7:0] data, input logic valid,
                                     input logic last);
        out_beat_t beat;
        beat.data  = data;
        beat.valid = valid;
        beat.last  = last;
        expected_bytes.insert(expected_bytes.size(), beat);
    endfunction

    // model of one accepted item: table update or the bytes it produces
    task automatic pack_predict(input pcbp_pkg::op_t op, input logic [7:0] sym,
                                input logic [31:0] word, input logic [5:0] len);
        logic [5:0]  clen;
        logic [2:0]  pad;
        logic [63:0] acc;
        int          cnt;
        begin
            case (op)
                pcbp_pkg::OP_LOAD: begin
                    clen = (len > pcbp_pkg::LEN_CAP) ? 6'(pcbp_pkg::LEN_CAP) : len;
                    word_of_sym[sym] = word & 32'((64'd1 << clen) - 64'd1);
                    len_of_sym[sym]  = clen;
                end
                pcbp_pkg::OP_START: begin
                    pad = 3'd0 - pad_total_bits[2:0];
                    add_beat({5'd0, pad}, 1'b1, 1'b0);
                    carry_bits = '0;
                    carry_cnt  = '0;
                end
                pcbp_pkg::OP_ENCODE: begin
                    clen = len_of_sym[sym];
                    if (clen != 0) begin
                        acc = ({57'd0, carry_bits} << clen) | {32'd0, word_of_sym[sym]};
                        cnt = int'(carry_cnt) + int'(clen);
                        while (cnt >= 8) begin
                            add_beat(8'(acc >> (cnt - 8)), 1'b1, 1'b0);
                            cnt = cnt - 8;
                        end
                        carry_cnt  = 3'(cnt);
                        carry_bits = 7'(acc & ((64'd1 << cnt) - 64'd1));
                    end
                end
                default: begin
                    if (carry_cnt != 0) begin
                        add_beat({1'b0, carry_bits}, 1'b1, 1'b1);
                    end else begin
                        add_beat(8'd0, 1'b0, 1'b1);
                    end
                    carry_bits = '0;
                    carry_cnt  = '0;
                end
            endcase
        end
    endtask

    // offer one item after a random idle gap and wait for its transfer
    task automatic send_item(input pcbp_pkg::op_t op, input logic [7:0] sym,
                             input logic [31:0] word, input logic [5:0] len);
        begin
            while ($urandom_range(99) < tx_idle_pct) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
            s_tdata  <= {2'b00, len, word, sym};
            s_tuser  <= op;
            s_tvalid <= 1'b1;
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            items_sent = items_sent + 1;
            pack_predict(op, sym, word, len);
        end
    endtask

    // stop offering, wait for every expected byte, then let loads settle
    task automatic drain_results();
        begin
            s_tvalid <= 1'b0;
            while (expected_bytes.size() != 0) @(posedge aclk);
            repeat (SETTLE_CYCLES) @(posedge aclk);
        end
    endtask

    // write the total bit count register; only called while idle
    task automatic write_total_bits(input logic [31:0] value);
        begin
            cfg_wr_data <= value;
            cfg_wr_en   <= 1'b1;
            @(posedge aclk);
            pad_total_bits = value;
            cfg_wr_en <= 1'b0;
            @(posedge aclk);
        end
    endtask

    function automatic logic [5:0] pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 8) return 6'd0;
        if (r < 13) return 6'($urandom_range(63, 33));
        if (r < 28) return 6'($urandom_range(32, 20));
        return 6'($urandom_range(12, 1));
    endfunction

    // header with default register, encode of an empty entry, flush with nothing held
    task automatic test_reset_state();
        begin
            send_item(pcbp_pkg::OP_START, 8'h00, 32'h0, 6'd0);
            send_item(pcbp_pkg::OP_ENCODE, 8'h3C, 32'h0, 6'd0);
            send_item(pcbp_pkg::OP_FINISH, 8'h00, 32'h0, 6'd0);
            drain_results();
        end
    endtask

    // length extremes, capping, masking, absent symbols, four-byte encodes
    task automatic test_table_limits();
        begin
            write_total_bits(32'hFFFF_FFFF);
            send_item(pcbp_pkg::OP_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd1);
            send_item(pcbp_pkg::OP_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32);
            send_item(pcbp_pkg::OP_LOAD, 8'hA5, 32'h1234_5678, 6'd63);
            send_item(pcbp_pkg::OP_LOAD, 8'h5A, 32'h0F0F_0F0F, 6'd33);
            send_item(pcbp_pkg::OP_LOAD, 8'h81, 32'hFFFF_FFAA, 6'd7);
            send_item(pcbp_pkg::OP_LOAD, 8'h42, 32'hDEAD_BEEF, 6'd0);
            send_item(pcbp_pkg::OP_START, 8'h00, 32'h0, 6'd0);
            // seven bits held, then a full-width code completes four bytes
            send_item(pcbp_pkg::OP_ENCODE, 8'h81, 32'h0, 6'd0);
            send_item(pcbp_pkg::OP_ENCODE, 8'hFF, 32'h0, 6'd0);
            send_item(pcbp_pkg::OP_ENCODE, 8'hA5, 32'h0, 6'd0);
            send_item(pcbp_pkg::OP_ENCODE, 8'h5A, 32'h0, 6'd0);
            send_item(pcbp_pkg::OP_ENCODE, 8'h42, 32'hFFFF_FFFF, 6'd63);
            send_item(pcbp_pkg::OP_ENCODE, 8'h00, 32'h0, 6'd0);
            send_item(pcbp_pkg::OP_FINISH, 8'hFF, 32'hFFFF_FFFF, 6'd63);
            // start throws away held bits
            send_item(pcbp_pkg::OP_START, 8'h00, 32'h0, 6'd0);
            send_item(pcbp_pkg::OP_ENCODE, 8'h00, 32'h0, 6'd0);
            send_item(pcbp_pkg::OP_ENCODE, 8'h00, 32'h0, 6'd0);
            send_item(pcbp_pkg::OP_START, 8'h00, 32'h0, 6'd0);
            send_item(pcbp_pkg::OP_ENCODE, 8'h81, 32'h0, 6'd0);
            send_item(pcbp_pkg::OP_FINISH, 8'h00, 32'h0, 6'd0);
            drain_results();
            write_total_bits(32'd8);
            send_item(pcbp_pkg::OP_START, 8'h00, 32'h0, 6'd0);
            drain_results();
            write_total_bits(32'd7);
            send_item(pcbp_pkg::OP_START, 8'h00, 32'h0, 6'd0);
            drain_results();
        end
    endtask

    // receiver holds off while long codes keep arriving, so the input stalls
    task automatic test_backpressure();
        int k;
        begin
            tx_idle_pct  = 0;
            rx_stall_pct = 0;
            send_item(pcbp_pkg::OP_LOAD, 8'hFF, $urandom, 6'd32);
            send_item(pcbp_pkg::OP_LOAD, 8'h81, $urandom, 6'd7);
            rx_hold_left = HOLD_CYCLES;
            send_item(pcbp_pkg::OP_START, 8'h00, 32'h0, 6'd0);
            send_item(pcbp_pkg::OP_ENCODE, 8'h81, 32'h0, 6'd0);
            for (k = 0; k < 24; k++) begin
                send_item(pcbp_pkg::OP_ENCODE, 8'hFF, $urandom, 6'($urandom));
            end
            send_item(pcbp_pkg::OP_FINISH, 8'h00, 32'h0, 6'd0);
            drain_results();
        end
    endtask

    // one message: loads, header, encodes, flush, with noise and broken framing
    task automatic random_message();
        logic [7:0]  pool [6];
        logic [31:0] total;
        int          n_pool;
        int          n_enc;
        int          k;
        begin
            if ($urandom_range(2) == 0) begin
                case ($urandom_range(3))
                    0:       total = 32'd0;
                    1:       total = 32'hFFFF_FFFF;
                    default: total = $urandom;
                endcase
                drain_results();
                write_total_bits(total);
            end
            n_pool = $urandom_range(6, 1);
            for (k = 0; k < n_pool; k++) begin
                pool[k] = 8'($urandom);
                send_item(pcbp_pkg::OP_LOAD, pool[k], $urandom, pick_len());
            end
            if ($urandom_range(9) != 0) begin
                send_item(pcbp_pkg::OP_START, 8'($urandom), $urandom, 6'($urandom));
            end
            n_enc = $urandom_range(12, 2);
            for (k = 0; k < n_enc; k++) begin
                if ($urandom_range(99) < 12) begin
                    send_item(pcbp_pkg::op_t'($urandom_range(3)), 8'($urandom), $urandom,
                              6'($urandom));
                end
                send_item(pcbp_pkg::OP_ENCODE, pool[$urandom_range(n_pool - 1)], $urandom,
                          6'($urandom));
            end
            if ($urandom_range(9) != 0) begin
                send_item(pcbp_pkg::OP_FINISH, 8'($urandom), $urandom, 6'($urandom));
            end
        end
    endtask

    task automatic run_random_phase(input int tx_pct, input int rx_pct);
        int start_count;
        begin
            tx_idle_pct  = tx_pct;
            rx_stall_pct = rx_pct;
            start_count  = items_sent;
            while (items_sent - start_count < PHASE_ITEMS) random_message();
            drain_results();
        end
    endtask

    // random messages under each idling mix
    task automatic test_random_traffic();
        begin
            run_random_phase(0, 0);
            run_random_phase(67, 0);
            run_random_phase(0, 67);
            run_random_phase(23, 23);
        end
    endtask

    initial begin
        foreach (len_of_sym[i]) begin
            len_of_sym[i]  = '0;
            word_of_sym[i] = '0;
        end
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_table_limits();
        test_backpressure();
        test_random_traffic();

        drain_results();
        if (expected_bytes.size() != 0) begin
            report_mismatch("bytes never produced", 32'(expected_bytes.size()), 32'd0);
        end
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
design/pcbp_pkg.sv
design/pcbp_code_table.sv
design/pcbp_packer.sv
design/pcbp_out_buf.sv
design/prefix_code_bit_packer.sv
test/prefix_code_bit_packer_tb.sv
